// ----- rtl/feistel_int32_permutation_core_assert.svh -----
// ----------------------------------------------------------------------------
// Feistel permutation core assertion macros
// Shared macros for the concurrent checks of the permutation core.
// ----------------------------------------------------------------------------
`ifndef FEISTEL_INT32_PERMUTATION_CORE_ASSERT_SVH
`define FEISTEL_INT32_PERMUTATION_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FIP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("feistel core: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("feistel core: next-cycle check failed");

`endif

// ----- rtl/fip_pkg.sv -----
// ----------------------------------------------------------------------------
// Feistel permutation package
// Constants, register map and shared types of the permutation core.
// ----------------------------------------------------------------------------
package fip_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned HALF_W = 16;
    localparam int unsigned ADDR_W = 3;

    localparam logic [WORD_W-1:0] LCG_MUL = 32'd1664525;
    localparam logic [WORD_W-1:0] LCG_ADD = 32'd1013904223;

    localparam logic REG_SECRET_KEY = 1'b0;

    typedef struct packed {
        logic              wr;
        logic [WORD_W-1:0] key;
    } t_key_wr;

    typedef enum logic [3:0] {
        S_EXPAND = 4'b0001,
        S_IDLE   = 4'b0010,
        S_ADD    = 4'b0100,
        S_MIX    = 4'b1000
    } t_state;

endpackage

// ----- rtl/feistel_int32_permutation_core.sv -----
// ----------------------------------------------------------------------------
// Feistel 32-bit permutation core
// Keyed balanced Feistel network on two 16-bit halves with LCG subkeys.
//
// Channel  Direction  tdata (low bit up)  tuser
// s_axis   in         data_in[31:0]       func
// m_axis   out        data_out[31:0]      -
// apb      in/out     secret_key at 0x0   -
//
// A new input beat is accepted only in the idle state, once the previous
// result has been written to the output register. Each round passes through
// an add state for the subkey sum and a mix state through the one shared
// multiply-add unit.
// After reset and after each key write the subkeys are expanded through the
// same unit, and no beat is accepted during the expansion.
// The result sits in an output register; the last round waits until it drains.
// ----------------------------------------------------------------------------
module feistel_int32_permutation_core
    import fip_pkg::*;
#(
    parameter int unsigned NUM_ROUNDS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [WORD_W-1:0] s_axis_tdata,   // data_in[31:0]
    input  logic              s_axis_tuser,   // func
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [WORD_W-1:0] m_axis_tdata,   // data_out[31:0]
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0] pwdata,
    output logic [WORD_W-1:0] prdata,
    output logic              pready
);

`include "feistel_int32_permutation_core_assert.svh"

    localparam int unsigned CW = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
    localparam logic [CW-1:0] LAST = CW'(NUM_ROUNDS - 1);
    localparam t_state START = (NUM_ROUNDS > 1) ? S_EXPAND : S_IDLE;

    t_key_wr           w_key_wr;
    logic [WORD_W-1:0] w_mac;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_rnd, n_rnd;
    logic [WORD_W-1:0] r_opnd, n_opnd;
    logic [HALF_W-1:0] r_l, n_l;
    logic [HALF_W-1:0] r_r, n_r;
    logic              r_inv, n_inv;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_data, n_out_data;
    logic [WORD_W-1:0] r_sub [NUM_ROUNDS];

    logic              w_sub_we;
    logic [CW-1:0]     w_sub_idx;
    logic [WORD_W-1:0] w_sub_wd;
    logic [CW-1:0]     w_rd_idx;
    logic              w_out_free;
    logic              w_in_acc;

    fip_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_key_wr (w_key_wr)
    );

    fip_lcg_unit u_lcg (
        .i_opnd   (r_opnd),
        .o_result (w_mac)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !w_key_wr.wr;
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_rd_idx      = r_inv ? (LAST - r_rnd) : r_rnd;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_rnd       = r_rnd;
        n_opnd      = r_opnd;
        n_l         = r_l;
        n_r         = r_r;
        n_inv       = r_inv;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !m_axis_tready;
        w_sub_we    = 1'b0;
        w_sub_idx   = r_rnd;
        w_sub_wd    = w_mac;

        if (w_key_wr.wr) begin
            w_sub_we  = 1'b1;
            w_sub_idx = '0;
            w_sub_wd  = w_key_wr.key;
            n_opnd    = w_key_wr.key;
            n_rnd     = CW'(1);
            n_state   = START;
        end else begin
            case (r_state)
                S_EXPAND: begin
                    w_sub_we = 1'b1;
                    n_opnd   = w_mac;
                    if (r_rnd == LAST) begin
                        n_rnd   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_rnd = r_rnd + CW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        n_l     = s_axis_tdata[WORD_W-1:HALF_W];
                        n_r     = s_axis_tdata[HALF_W-1:0];
                        n_inv   = s_axis_tuser;
                        n_rnd   = '0;
                        n_state = S_ADD;
                    end
                end
                S_ADD: begin
                    n_opnd  = {{(WORD_W-HALF_W){1'b0}}, r_sub[w_rd_idx][HALF_W-1:0] + r_r};
                    n_state = S_MIX;
                end
                S_MIX: begin
                    if (r_rnd != LAST) begin
                        n_l     = r_r;
                        n_r     = r_l ^ w_mac[HALF_W-1:0];
                        n_rnd   = r_rnd + CW'(1);
                        n_state = S_ADD;
                    end else if (w_out_free) begin
                        n_out_data  = {r_l ^ w_mac[HALF_W-1:0], r_r};
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= START;
            r_rnd       <= CW'(1);
            r_opnd      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rnd       <= n_rnd;
            r_opnd      <= n_opnd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l        <= n_l;
        r_r        <= n_r;
        r_inv      <= n_inv;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub[0] <= '0;
        end else if (w_sub_we) begin
            r_sub[w_sub_idx] <= w_sub_wd;
        end
    end

    `FIP_ASSERT_NEXT(a_accept_starts_round, i_clk, i_rst_n, w_in_acc && !w_key_wr.wr, r_state == S_ADD)
    `FIP_ASSERT_NEXT(a_last_round_emits, i_clk, i_rst_n, (r_state == S_MIX) && (r_rnd == LAST) && w_out_free && !w_key_wr.wr, r_out_valid)
    `FIP_ASSERT_NEXT(a_key_lands_in_sub0, i_clk, i_rst_n, w_key_wr.wr, r_sub[0] == $past(w_key_wr.key))
    `FIP_ASSERT_IMPLY(a_expand_skips_sub0, i_clk, i_rst_n, r_state == S_EXPAND, r_rnd != '0)

endmodule

// ----- rtl/fip_lcg_unit.sv -----
// ----------------------------------------------------------------------------
// Feistel LCG multiply-add unit
// Shared step x * 1664525 + 1013904223 mod 2^32, used for subkey expansion
// and for the round function.
// ----------------------------------------------------------------------------
module fip_lcg_unit
    import fip_pkg::*;
(
    input  logic [WORD_W-1:0] i_opnd,
    output logic [WORD_W-1:0] o_result
);

    logic [WORD_W-1:0] w_prod;

    assign w_prod   = i_opnd * LCG_MUL;
    assign o_result = w_prod + LCG_ADD;

endmodule

// ----- rtl/fip_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Feistel configuration registers
// APB-style register port holding the secret key.
// ----------------------------------------------------------------------------
module fip_cfg_regs
    import fip_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0] pwdata,
    output logic [WORD_W-1:0] prdata,
    output logic              pready,
    output t_key_wr           o_key_wr
);

    logic [WORD_W-1:0] r_key;
    logic              w_hit;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_hit  = (paddr[ADDR_W-1:2] == REG_SECRET_KEY);
    assign w_wr   = psel & penable & pwrite & w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (w_wr) begin
            r_key <= pwdata;
        end
    end

    assign prdata       = w_hit ? r_key : '0;
    assign o_key_wr.wr  = w_wr;
    assign o_key_wr.key = pwdata;

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Feistel permutation core testbench
// Drives values and directions into the stream input, predicts each result
// with an independent model of the rounds and the subkey expansion, and
// compares every output beat in order. The key is rewritten between phases
// over the register port, and both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import fip_pkg::*;

    localparam int unsigned NUM_ROUNDS   = 4;
    localparam int unsigned DRAIN_CYCLES = 2 * NUM_ROUNDS + 5;
    localparam int unsigned CYCLE_LIMIT  = 250000;
    localparam int unsigned MAX_REPORTS  = 10;

    localparam logic [ADDR_W-1:0] KEY_ADDR      = ADDR_W'(REG_SECRET_KEY) << 2;
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = KEY_ADDR + ADDR_W'(4);

    localparam logic FUNC_FORWARD = 1'b0;
    localparam logic FUNC_INVERSE = 1'b1;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [WORD_W-1:0] s_axis_tdata  = '0;
    logic              s_axis_tuser  = FUNC_FORWARD;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [WORD_W-1:0] m_axis_tdata;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [WORD_W-1:0] pwdata        = '0;
    logic [WORD_W-1:0] prdata;
    logic              pready;

    logic [WORD_W-1:0] key_value;
    logic [WORD_W-1:0] round_keys [NUM_ROUNDS];
    logic [WORD_W-1:0] pending_words [$];
    logic [WORD_W-1:0] last_forward;
    bit                have_forward  = 1'b0;
    bit                tx_idle_en    = 1'b0;
    bit                rx_idle_en    = 1'b0;
    int unsigned       rx_hold_left  = 0;
    int unsigned       rx_stall_left = 0;
    int unsigned       fault_count   = 0;

    feistel_int32_permutation_core #(
        .NUM_ROUNDS(NUM_ROUNDS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // data_in[31:0]
        .s_axis_tuser (s_axis_tuser),   // func
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),   // data_out[31:0]
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic void load_key_schedule(logic [WORD_W-1:0] key);
        key_value     = key;
        round_keys[0] = key;
        for (int i = 1; i < NUM_ROUNDS; i++) begin
            round_keys[i] = round_keys[i-1] * LCG_MUL + LCG_ADD;
        end
    endfunction

    function automatic logic [WORD_W-1:0] permute_word(logic inverse, logic [WORD_W-1:0] word);
        logic [HALF_W-1:0] left;
        logic [HALF_W-1:0] right;
        logic [HALF_W-1:0] carry;
        logic [WORD_W-1:0] mix;
        int                idx;
        left  = word[WORD_W-1:HALF_W];
        right = word[HALF_W-1:0];
        for (int n = 0; n < NUM_ROUNDS; n++) begin
            idx   = inverse ? NUM_ROUNDS - 1 - n : n;
            mix   = (round_keys[idx] + WORD_W'(right)) * LCG_MUL + LCG_ADD;
            carry = right;
            right = left ^ mix[HALF_W-1:0];
            left  = carry;
        end
        return {right, left};
    endfunction

    task automatic report_fault(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
            $display("%s: expected %08h, got %08h", what, want, got);
        end
    endtask

    // Result checker: samples between edges, the beat completes at the next edge.
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_words.size() == 0) begin
                report_fault("unexpected output beat", '0, m_axis_tdata);
            end else begin
                if (pending_words[0] !== m_axis_tdata) begin
                    report_fault("data_out mismatch", pending_words[0], m_axis_tdata);
                end
                void'(pending_words.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_left - 1;
        end else if (rx_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left <= $urandom_range(1, 14) - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_beat(logic func, logic [WORD_W-1:0] word);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= func;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        pending_words.push_back(permute_word(func, word));
        if (func == FUNC_FORWARD) begin
            last_forward = permute_word(func, word);
            have_forward = 1'b1;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == KEY_ADDR) begin
            load_key_schedule(value);
        end
    endtask

    task automatic check_key_readback();
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= KEY_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        if (prdata !== key_value) begin
            report_fault("secret_key readback", key_value, prdata);
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_random_items(int unsigned count);
        logic func;
        for (int unsigned i = 0; i < count; i++) begin
            if (have_forward && $urandom_range(0, 4) == 0) begin
                send_beat(FUNC_INVERSE, last_forward);
            end else begin
                func = 1'($urandom_range(0, 1));
                send_beat(func, $urandom);
            end
        end
    endtask

    task automatic test_reset_key();
        logic [WORD_W-1:0] corners [8];
        corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000,
                    32'h8000_0000, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA};
        check_key_readback();
        foreach (corners[i]) begin
            send_beat(FUNC_FORWARD, corners[i]);
            send_beat(FUNC_INVERSE, corners[i]);
        end
    endtask

    task automatic test_key_extremes();
        logic [WORD_W-1:0] keys [4];
        keys = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h0000_0000};
        foreach (keys[i]) begin
            write_reg(KEY_ADDR, keys[i]);
            check_key_readback();
            send_beat(FUNC_FORWARD, 32'h1234_ABCD);
            send_beat(FUNC_INVERSE, last_forward);
        end
    endtask

    task automatic test_unmapped_write();
        write_reg(KEY_ADDR, 32'hC001_D00D);
        write_reg(UNMAPPED_ADDR, $urandom);
        check_key_readback();
        send_beat(FUNC_FORWARD, 32'hDEAD_BEEF);
        send_beat(FUNC_INVERSE, 32'hDEAD_BEEF);
    endtask

    task automatic test_random_traffic();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int k = 0; k < 5; k++) begin
            write_reg(KEY_ADDR, $urandom);
            send_random_items(130);
        end
    endtask

    task automatic test_backpressure();
        tx_idle_en   = 1'b0;
        rx_hold_left = 300;
        send_random_items(30);
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
        send_random_items(40);
        wait_drained();
        send_random_items(40);
    endtask

    task automatic test_full_rate_tail();
        write_reg(KEY_ADDR, $urandom);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random_items(150);
    endtask

    initial begin
        load_key_schedule('0);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_key();
        test_key_extremes();
        test_unmapped_write();
        test_random_traffic();
        test_backpressure();
        test_full_rate_tail();
        wait_drained();
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && pending_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/fip_pkg.sv
rtl/fip_lcg_unit.sv
rtl/fip_cfg_regs.sv
rtl/feistel_int32_permutation_core.sv
sim/testbench.sv
